/* src/cbd_pkg.sv */
// shared types and constants of the console cpu bus decoder
package cbd_pkg;

	localparam int WORK_RAM_BYTES = 2048;
	localparam int SAVE_RAM_BYTES = 8192;
	localparam int WRAM_AW        = $clog2(WORK_RAM_BYTES);
	localparam int SRAM_AW        = $clog2(SAVE_RAM_BYTES);
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

	localparam logic [15:0] ADDR_PPU_BASE    = 16'h2000;
	localparam logic [15:0] ADDR_IO_BASE     = 16'h4000;
	localparam logic [15:0] ADDR_OAM_DMA     = 16'h4014;
	localparam logic [15:0] ADDR_PAD_ONE     = 16'h4016;
	localparam logic [15:0] ADDR_PAD_TWO     = 16'h4017;
	localparam logic [15:0] ADDR_CART_BASE   = 16'h4020;
	localparam logic [15:0] ADDR_SAVE_BASE   = 16'h6000;
	localparam logic [15:0] ADDR_ROM_BASE    = 16'h8000;

	localparam logic [9:0] OAM_HOLD_CYCLES = 10'd513;
	localparam logic [7:0] PAD_OPEN_BUS    = 8'h40;

	typedef enum logic [2:0] {
		ROUTE_WRAM    = 3'd0,
		ROUTE_SRAM    = 3'd1,
		ROUTE_PPU     = 3'd2,
		ROUTE_ROM     = 3'd3,
		ROUTE_PAD     = 3'd4,
		ROUTE_MAPPER  = 3'd5,
		ROUTE_IGNORED = 3'd6,
		ROUTE_DMA     = 3'd7
	} route_t;

	// what the back end has to do with an access
	typedef enum logic [2:0] {
		OP_PASS,
		OP_WRAM_RD,
		OP_WRAM_WR,
		OP_SRAM_RD,
		OP_SRAM_WR,
		OP_PAD_RD,
		OP_STROBE_WR
	} op_t;

	typedef struct packed {
		op_t         op;
		route_t      route;
		logic        is_write;
		logic [15:0] addr;
		logic [7:0]  wval;
		logic [7:0]  ext;
		logic [7:0]  pad_one;
		logic [7:0]  pad_two;
	} entry_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} back_ctrl_t;

endpackage

/* src/cbd_ram.sv */
// generic single write port ram with registered read
module cbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/cbd_front.sv */
// front end: accepts bus accesses, classifies them and queues them
module cbd_front import cbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,
	input  logic [0:0]  s_axis_tuser,
	input  back_ctrl_t  ctrl,
	output entry_t      head,
	output logic        head_valid
);

	entry_t            fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	entry_t            cls;
	logic              push;
	logic [15:0]       addr;

	assign addr = s_axis_tdata[15:0];

	always_comb begin
		cls          = '0;
		cls.is_write = s_axis_tuser[0];
		cls.addr     = addr;
		cls.wval     = s_axis_tdata[23:16];
		cls.ext      = s_axis_tdata[31:24];
		cls.pad_one  = s_axis_tdata[39:32];
		cls.pad_two  = s_axis_tdata[47:40];
		cls.op       = OP_PASS;
		cls.route    = ROUTE_IGNORED;
		if (!s_axis_tuser[0]) begin
			if (addr >= ADDR_ROM_BASE) begin
				cls.route = ROUTE_ROM;
			end else if (addr >= ADDR_SAVE_BASE) begin
				cls.route = ROUTE_SRAM;
				cls.op    = OP_SRAM_RD;
			end else if (addr < ADDR_PPU_BASE) begin
				cls.route = ROUTE_WRAM;
				cls.op    = OP_WRAM_RD;
			end else if (addr < ADDR_IO_BASE) begin
				cls.route = ROUTE_PPU;
			end else if (addr == ADDR_PAD_ONE || addr == ADDR_PAD_TWO) begin
				cls.route = ROUTE_PAD;
				cls.op    = OP_PAD_RD;
			end
		end else begin
			if (addr < ADDR_PPU_BASE) begin
				cls.route = ROUTE_WRAM;
				cls.op    = OP_WRAM_WR;
			end else if (addr < ADDR_IO_BASE) begin
				cls.route = ROUTE_PPU;
			end else if (addr == ADDR_OAM_DMA) begin
				cls.route = ROUTE_DMA;
			end else if (addr == ADDR_PAD_ONE) begin
				cls.route = ROUTE_PAD;
				cls.op    = OP_STROBE_WR;
			end else if (addr >= ADDR_SAVE_BASE && addr < ADDR_ROM_BASE) begin
				cls.route = ROUTE_SRAM;
				cls.op    = OP_SRAM_WR;
			end else if (addr >= ADDR_CART_BASE) begin
				cls.route = ROUTE_MAPPER;
			end
		end
	end

	assign s_axis_tready = !ctrl.clearing && (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign head_valid    = (count_q != '0);
	assign head          = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (ctrl.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !ctrl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && ctrl.pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

endmodule

/* src/cbd_back.sv */
// back end: rams, controller ports, result formatting and output register
module cbd_back import cbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	input  logic        head_valid,
	output back_ctrl_t  ctrl,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser
);

	logic               clearing_q;
	logic [SRAM_AW-1:0] clr_cnt_q;
	logic [7:0]         pad_one_q;
	logic [7:0]         pad_two_q;
	logic               strobe_q;
	logic               valid_s1;
	entry_t             ent_s1;
	logic               pad_bit_s1;
	logic               m_valid_q;
	logic [71:0]        m_tdata_q;
	logic [2:0]         m_tuser_q;
	logic               advance;
	logic               pop;
	logic               pad_bit;

	logic               wram_we;
	logic [WRAM_AW-1:0] wram_waddr;
	logic [7:0]         wram_wdata;
	logic               wram_re;
	logic [7:0]         wram_rdata;
	logic               sram_we;
	logic [SRAM_AW-1:0] sram_waddr;
	logic [7:0]         sram_wdata;
	logic               sram_re;
	logic [7:0]         sram_rdata;

	logic [7:0]         res_rdata;
	logic [12:0]        res_toff;
	logic [1:0]         res_slot;
	logic [15:0]        res_faddr;
	logic [7:0]         res_fval;
	logic [7:0]         res_page;
	logic [9:0]         res_stall;

	assign advance = !m_valid_q || m_axis_tready;
	assign pop     = head_valid && !clearing_q && (!valid_s1 || advance);
	assign ctrl    = '{clearing: clearing_q, pop: pop};
	assign pad_bit = head.addr[0] ? pad_two_q[7] : pad_one_q[7];

	// rams: clearing sweep overrides the access path
	assign wram_we    = clearing_q || (pop && head.op == OP_WRAM_WR);
	assign wram_waddr = clearing_q ? clr_cnt_q[WRAM_AW-1:0] : head.addr[WRAM_AW-1:0];
	assign wram_wdata = clearing_q ? 8'h00 : head.wval;
	assign wram_re    = pop && head.op == OP_WRAM_RD;
	assign sram_we    = clearing_q || (pop && head.op == OP_SRAM_WR);
	assign sram_waddr = clearing_q ? clr_cnt_q : head.addr[SRAM_AW-1:0];
	assign sram_wdata = clearing_q ? 8'h00 : head.wval;
	assign sram_re    = pop && head.op == OP_SRAM_RD;

	cbd_ram #(.WIDTH(8), .DEPTH(WORK_RAM_BYTES)) u_wram (
		.clk   (clk),
		.we    (wram_we),
		.waddr (wram_waddr),
		.wdata (wram_wdata),
		.re    (wram_re),
		.raddr (head.addr[WRAM_AW-1:0]),
		.rdata (wram_rdata)
	);

	cbd_ram #(.WIDTH(8), .DEPTH(SAVE_RAM_BYTES)) u_sram (
		.clk   (clk),
		.we    (sram_we),
		.waddr (sram_waddr),
		.wdata (sram_wdata),
		.re    (sram_re),
		.raddr (head.addr[SRAM_AW-1:0]),
		.rdata (sram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			pad_one_q  <= '0;
			pad_two_q  <= '0;
			strobe_q   <= 1'b0;
			valid_s1   <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == SRAM_AW'(SAVE_RAM_BYTES - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (pop && head.op == OP_PAD_RD) begin
				if (head.addr[0]) begin
					pad_two_q <= {pad_two_q[6:0], 1'b0};
				end else begin
					pad_one_q <= {pad_one_q[6:0], 1'b0};
				end
			end
			if (pop && head.op == OP_STROBE_WR) begin
				if (head.wval[0]) begin
					strobe_q <= 1'b1;
				end else if (strobe_q) begin
					pad_one_q <= head.pad_one;
					pad_two_q <= head.pad_two;
					strobe_q  <= 1'b0;
				end
			end
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				m_valid_q <= valid_s1;
			end
		end
	end

	always_comb begin
		res_rdata = 8'h00;
		case (ent_s1.op)
			OP_WRAM_RD: res_rdata = wram_rdata;
			OP_SRAM_RD: res_rdata = sram_rdata;
			OP_PAD_RD:  res_rdata = PAD_OPEN_BUS | {7'b0, pad_bit_s1};
			OP_PASS: begin
				if (!ent_s1.is_write && ent_s1.route inside {ROUTE_PPU, ROUTE_ROM}) begin
					res_rdata = ent_s1.ext;
				end
			end
			default: res_rdata = 8'h00;
		endcase
		res_toff  = '0;
		res_slot  = '0;
		res_faddr = '0;
		res_fval  = '0;
		res_page  = '0;
		res_stall = '0;
		case (ent_s1.route)
			ROUTE_PPU: begin
				res_toff = {10'b0, ent_s1.addr[2:0]};
				if (ent_s1.is_write) begin
					res_fval = ent_s1.wval;
				end
			end
			ROUTE_ROM: begin
				res_toff = ent_s1.addr[12:0];
				res_slot = ent_s1.addr[14:13];
			end
			ROUTE_MAPPER: begin
				res_faddr = ent_s1.addr;
				res_fval  = ent_s1.wval;
			end
			ROUTE_DMA: begin
				res_page  = ent_s1.wval;
				res_stall = OAM_HOLD_CYCLES;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s1     <= head;
			pad_bit_s1 <= pad_bit;
		end
		if (advance && valid_s1) begin
			m_tdata_q <= {7'b0, res_stall, res_page, res_fval, res_faddr,
			              res_slot, res_toff, res_rdata};
			m_tuser_q <= ent_s1.route;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

endmodule

/* src/console_cpu_bus_decoder_top.sv */
// top level of the console cpu bus decoder
//
// Decodes one CPU bus access per transfer against the console memory map and
// returns one result transfer per access. Work RAM (2 KB, mirrored below
// 0x2000) and save RAM (8 KB at 0x6000) live inside, as do both controller
// shift registers and the strobe latch; picture-unit registers, program ROM
// and mapper writes are routed outward, with the byte for external reads
// carried in the access itself. A write to 0x4014 reports a DMA start with
// stall_cycles set to 513. Accesses enter a front end that classifies them
// into a two-entry queue; a back end drains the queue, performs the RAM and
// controller side effects and formats the result into an output register.
// One access per clock while the result channel is ready and no sweep runs;
// an access passes the queue, the stage-one register beside the registered
// RAM read, and the output register. After reset both RAMs are swept to zero,
// one entry per clock over the save RAM depth, with s_axis_tready held low.
module console_cpu_bus_decoder_top import cbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// access channel
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// bus_address, write_value, external_data, pad_one_buttons, pad_two_buttons
	input  logic [47:0] s_axis_tdata,
	// req_type
	input  logic [0:0]  s_axis_tuser,
	// result channel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data, target_offset, rom_slot, forward_address, forward_value,
	// dma_page, stall_cycles, zero fill
	output logic [71:0] m_axis_tdata,
	// route
	output logic [2:0]  m_axis_tuser
);

	entry_t     head;
	logic       head_valid;
	back_ctrl_t ctrl;

	// classification and queueing of accepted transfers
	cbd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.ctrl          (ctrl),
		.head          (head),
		.head_valid    (head_valid)
	);

	// execution against rams and controller state, result register
	cbd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.ctrl          (ctrl),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
